/* hw/rtl/pree_pkg.sv */
// Shared types and constants for the palette range edit engine.
`default_nettype none
package pree_pkg;
    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_READ   = 3'd1,
        REQ_GRAD   = 3'd2,
        REQ_INVERT = 3'd3,
        REQ_DEDUCT = 3'd4
    } t_req;

    localparam logic [0:0] CFG_ENABLES = 1'b0;
    localparam logic [0:0] CFG_ALPHA   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_LO, ST_RD_HI, ST_WALK_RD, ST_WALK_WAIT,
        ST_DIV, ST_WALK_WR, ST_RESULT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture request fields
        logic rd_lo;     // read range low end
        logic rd_hi;     // read range high end
        logic rd_cur;    // read the current entry
        logic cap_lo;    // latch low end color
        logic cap_hi;    // latch high end color
        logic cap_cur;   // latch current entry color
        logic div_start; // start the four channel divisions
        logic wr_cur;    // write back the current entry
        logic step;      // advance the walk index
        logic clr_wr;    // clearing pass write
        logic wr_req;    // direct write request
        logic out_load;  // load the result register
    } t_cmd;

    typedef struct packed {
        logic walk_done; // the current write-back is the last one of the walk
        logic div_done;
        logic clr_done;
        logic grad_empty;
    } t_status;
endpackage
`default_nettype wire

/* hw/rtl/pree_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module pree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/pree_ctrl.sv */
// Sequencing state machine for the palette range edit engine.
`default_nettype none
module pree_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [2:0]        i_req,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire pree_pkg::t_status i_status,
    output pree_pkg::t_cmd         o_cmd
);
    import pree_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_req;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
            r_req       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (o_in_ready && i_in_valid) begin
                r_req <= i_req;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_req)
                        REQ_WRITE: begin
                            o_cmd.wr_req = 1'b1;
                            n_state = ST_RESULT;
                        end
                        REQ_READ: n_state = ST_RD_LO;
                        REQ_GRAD: n_state = ST_RD_LO;
                        REQ_INVERT, REQ_DEDUCT: n_state = ST_WALK_RD;
                        default: n_state = ST_RESULT;
                    endcase
                end
            end
            ST_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = (r_req == REQ_READ) ? ST_WALK_WAIT : ST_RD_HI;
            end
            ST_RD_HI: begin
                o_cmd.rd_hi  = 1'b1;
                o_cmd.cap_lo = 1'b1;
                n_state = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                if (r_req == REQ_GRAD) begin
                    o_cmd.cap_hi = 1'b1;
                    o_cmd.step   = 1'b1;
                    n_state = i_status.grad_empty ? ST_RESULT : ST_WALK_WAIT;
                end else begin
                    // An inclusive range always holds at least one entry.
                    o_cmd.rd_cur = 1'b1;
                    n_state = ST_WALK_WAIT;
                end
            end
            ST_WALK_WAIT: begin
                if (r_req == REQ_READ) begin
                    o_cmd.cap_cur = 1'b1;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    if (r_req == REQ_GRAD) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_WALK_WR;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.rd_cur = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_WALK_WR;
                end
            end
            ST_WALK_WR: begin
                o_cmd.cap_cur = 1'b1;
                o_cmd.wr_cur  = 1'b1;
                o_cmd.step    = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_WALK_WAIT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/pree_dp.sv */
// Datapath: palette memory, walk index, channel dividers and result register.
`default_nettype none
module pree_dp #(
    parameter int ENTRIES = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pree_pkg::t_cmd    i_cmd,
    output pree_pkg::t_status      o_status,
    input  wire logic [2:0]        i_req,
    input  wire logic [7:0]        i_first,
    input  wire logic [7:0]        i_second,
    input  wire logic [31:0]       i_wcolor,
    input  wire logic [4:0]        i_enables,
    input  wire logic              i_alpha,
    output logic [31:0]            o_read_color,
    output logic [2:0]             o_finished
);
    import pree_pkg::*;
    localparam int AW = $clog2(ENTRIES);
    localparam int NW = AW + 1;
    localparam int PW = 8 + AW;

    logic [AW-1:0] r_lo, r_hi, r_idx, r_clr;
    logic [2:0]    r_req;
    logic [31:0]   r_wcolor, r_c1, r_c2, r_cur;
    logic [31:0]   r_out;
    logic [2:0]    r_fin;
    logic [31:0]   w_rdata, w_wdata, w_mask, w_new;
    logic [AW-1:0] w_addr, w_a, w_b;
    logic          w_we;
    logic [NW-1:0] r_k;

    function automatic logic [AW-1:0] clampi(input logic [7:0] v);
        if ({{NW{1'b0}}, v} >= NW'(ENTRIES) + {(NW+8){1'b0}}) begin
            return AW'(ENTRIES - 1);
        end
        return AW'(v);
    endfunction

    assign w_a = clampi(i_first);
    assign w_b = clampi(i_second);

    // Divider state: restoring division, one quotient bit per cycle per lane.
    logic [PW-1:0] r_num [4];
    logic [PW-1:0] r_rem [4];
    logic [$clog2(PW+1)-1:0] r_cnt;
    logic r_div_busy;
    logic [NW-1:0] w_n;
    assign w_n = {1'b0, r_hi} - {1'b0, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_div_busy <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_div_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(PW+1))'(PW - 1)) begin
                    r_div_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_wcolor <= i_wcolor;
            // A read addresses the first index, whatever the second holds.
            r_lo     <= (i_req == REQ_READ) ? w_a : ((w_a < w_b) ? w_a : w_b);
            r_hi     <= (w_a < w_b) ? w_b : w_a;
            r_idx    <= (w_a < w_b) ? w_a : w_b;
            r_k      <= '0;
        end
        if (i_cmd.cap_lo) r_c1 <= w_rdata;
        if (i_cmd.cap_hi) r_c2 <= w_rdata;
        if (i_cmd.cap_cur) r_cur <= w_rdata;
        if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            r_k   <= r_k + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_fin <= r_req;
            r_out <= (r_req == REQ_READ) ? r_cur : 32'd0;
        end
        for (int ch = 0; ch < 4; ch++) begin
            if (i_cmd.div_start) begin
                r_num[ch] <= PW'(r_c1[ch*8 +: 8]) * PW'(w_n - r_k)
                           + PW'(r_c2[ch*8 +: 8]) * PW'(r_k);
                r_rem[ch] <= '0;
            end else if (r_div_busy) begin
                if ({r_rem[ch][PW-2:0], r_num[ch][PW-1]} >= PW'(w_n)) begin
                    r_rem[ch] <= {r_rem[ch][PW-2:0], r_num[ch][PW-1]} - PW'(w_n);
                    r_num[ch] <= {r_num[ch][PW-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= {r_rem[ch][PW-2:0], r_num[ch][PW-1]};
                    r_num[ch] <= {r_num[ch][PW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        w_mask = '0;
        if (i_enables[0]) begin
            if (i_enables[1]) w_mask[7:0]   = 8'hFF;
            if (i_enables[2]) w_mask[15:8]  = 8'hFF;
            if (i_enables[3]) w_mask[23:16] = 8'hFF;
        end
        if (i_enables[4] && i_alpha) w_mask[31:24] = 8'hFF;
    end

    logic [7:0] w_r, w_g, w_bl, w_mx, w_mn;
    logic [8:0] w_sum;
    logic [31:0] w_grad;
    assign w_r  = w_rdata[7:0];
    assign w_g  = w_rdata[15:8];
    assign w_bl = w_rdata[23:16];
    always_comb begin
        w_mx = w_r;
        w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_bl > w_mx) w_mx = w_bl;
        if (w_g < w_mn) w_mn = w_g;
        if (w_bl < w_mn) w_mn = w_bl;
        w_sum = {1'b0, w_mx} + {1'b0, w_mn};
        for (int ch = 0; ch < 4; ch++) begin
            w_grad[ch*8 +: 8] = r_num[ch][7:0];
        end
        case (r_req)
            REQ_GRAD:   w_new = (w_rdata & ~w_mask) | (w_grad & w_mask);
            REQ_INVERT: w_new = w_rdata ^ w_mask;
            REQ_DEDUCT: w_new = {w_sum[8:1], w_rdata[23:0]};
            default:    w_new = w_rdata;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_new;
        w_addr  = r_idx;
        if (i_cmd.clr_wr) begin
            w_we = 1'b1;
            w_wdata = '0;
            w_addr = r_clr;
        end else if (i_cmd.wr_req) begin
            w_we = 1'b1;
            w_wdata = i_wcolor;
            w_addr = w_a;
        end else if (i_cmd.rd_lo) begin
            w_addr = r_lo;
        end else if (i_cmd.rd_hi) begin
            w_addr = r_hi;
        end else if (i_cmd.wr_cur) begin
            w_we = 1'b1;
        end
    end

    pree_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // Last write-back: r_k at the range end, or one short of it for a gradient.
    assign o_status.walk_done  = (r_req == REQ_GRAD) ? (r_k + 1'b1 >= w_n)
                                                     : (r_k >= w_n);
    assign o_status.div_done   = !r_div_busy && !i_cmd.div_start;
    assign o_status.clr_done   = (r_clr == AW'(ENTRIES - 1));
    assign o_status.grad_empty = (w_n < NW'(2));
    assign o_read_color = r_out;
    assign o_finished   = r_fin;
    logic unused;
    assign unused = ^r_wcolor;
endmodule
`default_nettype wire

/* hw/rtl/palette_range_edit_engine_unit.sv */
// Invert and deduct-alpha walk every entry of the range; a gradient walks the inner
// entries through the per-channel bit-serial dividers. All requests share one memory port.
// One request is processed at a time; the result register holds until taken.
// After reset, a clearing pass zeroes the palette while the input stays stalled;
// configuration writes are taken at any time.
`default_nettype none
module palette_range_edit_engine_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_type[2:0], first_index[10:3], second_index[18:11], write_color[50:19]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_color[31:0], finished_type[34:32]
    output logic [39:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [4:0]  i_cfg_data
);
    import pree_pkg::*;

    logic [4:0] r_enables;
    logic       r_alpha;
    t_cmd       w_cmd;
    t_status    w_status;
    logic [31:0] w_rc;
    logic [2:0]  w_fin;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enables <= 5'd31;
            r_alpha   <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENABLES) r_enables <= i_cfg_data;
            if (i_cfg_index == CFG_ALPHA)   r_alpha   <= i_cfg_data[0];
        end
    end

    pree_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req      (s_axis_tdata[2:0]),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pree_dp #(.ENTRIES(PALETTE_ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_req       (s_axis_tdata[2:0]),
        .i_first     (s_axis_tdata[10:3]),
        .i_second    (s_axis_tdata[18:11]),
        .i_wcolor    (s_axis_tdata[50:19]),
        .i_enables   (r_enables),
        .i_alpha     (r_alpha),
        .o_read_color(w_rc),
        .o_finished  (w_fin)
    );

    assign m_axis_tdata = {5'd0, w_fin, w_rc};
    logic unused;
    assign unused = ^s_axis_tdata[55:51];
endmodule
`default_nettype wire

/* hw/rtl/pree_checker.sv */
// Port-level checker for the palette range edit engine, bound to the top level.
`default_nettype none
module pree_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import pree_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_rdzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[34:32] != REQ_READ |-> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero color on non-read result");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind palette_range_edit_engine_unit pree_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the palette range edit engine.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import pree_pkg::*;

    localparam int ENTRIES = 256;
    localparam int REQ_BAD = 5;

    typedef struct packed {
        logic [31:0] color;
        logic [7:0]  idx_b;
        logic [7:0]  idx_a;
        logic [2:0]  kind;
    } t_request;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  idx_a;
        logic [7:0]  idx_b;
        logic [31:0] color;
        bit          has_fixed;
        logic [31:0] fixed_color;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [4:0]  i_cfg_data;

    palette_range_edit_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow palette and registers.
    logic [31:0] shadow_pal [ENTRIES];
    logic [4:0]  shadow_enables;
    logic        shadow_alpha;

    logic [31:0] exp_color_q[$];
    logic [2:0]  exp_kind_q[$];
    int          mismatches;
    bit          stall_random;

    function automatic logic [31:0] lane_mask();
        logic [31:0] m;
        m = '0;
        if (shadow_enables[0]) begin
            if (shadow_enables[1]) m[7:0] = 8'hFF;
            if (shadow_enables[2]) m[15:8] = 8'hFF;
            if (shadow_enables[3]) m[23:16] = 8'hFF;
        end
        if (shadow_enables[4] && shadow_alpha) m[31:24] = 8'hFF;
        return m;
    endfunction

    // Apply one request to the shadow palette and return the read value.
    function automatic logic [31:0] apply_request(t_request r);
        int lo, hi, n, v;
        logic [31:0] m, c1, c2, c, e;
        logic [7:0] mx, mn, x;
        lo = (r.idx_a < r.idx_b) ? r.idx_a : r.idx_b;
        hi = (r.idx_a < r.idx_b) ? r.idx_b : r.idx_a;
        m = lane_mask();
        case (r.kind)
            REQ_WRITE: shadow_pal[r.idx_a] = r.color;
            REQ_READ: return shadow_pal[r.idx_a];
            REQ_GRAD: begin
                n = hi - lo;
                c1 = shadow_pal[lo];
                c2 = shadow_pal[hi];
                for (int k = 1; k < n; k++) begin
                    for (int ch = 0; ch < 4; ch++) begin
                        v = (int'(c1[ch*8 +: 8]) * (n - k) + int'(c2[ch*8 +: 8]) * k) / n;
                        c[ch*8 +: 8] = v[7:0];
                    end
                    shadow_pal[lo+k] = (shadow_pal[lo+k] & ~m) | (c & m);
                end
            end
            REQ_INVERT: begin
                for (int i = lo; i <= hi; i++) shadow_pal[i] = shadow_pal[i] ^ m;
            end
            REQ_DEDUCT: begin
                for (int i = lo; i <= hi; i++) begin
                    e = shadow_pal[i];
                    mx = e[7:0];
                    mn = e[7:0];
                    for (int ch = 1; ch < 3; ch++) begin
                        x = e[ch*8 +: 8];
                        if (x > mx) mx = x;
                        if (x < mn) mn = x;
                    end
                    v = (int'(mx) + int'(mn)) >> 1;
                    shadow_pal[i] = {v[7:0], e[23:0]};
                end
            end
            default: ;
        endcase
        return '0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: stalls when stall_random is set, checks each taken result.
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_random)
                m_axis_tready <= (stall_phase % 11 < 7) && ($urandom_range(0, 3) != 0);
            else
                m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_color_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h", m_axis_tdata);
                end else begin
                    if (m_axis_tdata[31:0] !== exp_color_q[0] ||
                        m_axis_tdata[34:32] !== exp_kind_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: expected color %h kind %0d, got color %h kind %0d",
                                     exp_color_q[0], exp_kind_q[0],
                                     m_axis_tdata[31:0], m_axis_tdata[34:32]);
                    end
                    void'(exp_color_q.pop_front());
                    void'(exp_kind_q.pop_front());
                end
            end
        end
    end

    task automatic write_register(logic idx, logic [4:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ENABLES) shadow_enables = value;
        else shadow_alpha = value[0];
    endtask

    int burst_left;

    // Send one request; the expected result is either predicted or given.
    task automatic send_request(t_request r, bit has_fixed, logic [31:0] fixed_color);
        logic [31:0] predicted;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, r};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        predicted = apply_request(r);
        if (has_fixed && predicted !== fixed_color) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: predictor gives %h, table gives %h", predicted, fixed_color);
        end
        exp_color_q.push_back(has_fixed ? fixed_color : predicted);
        exp_kind_q.push_back(r.kind);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (exp_color_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return 8'($urandom_range(0, 15));
            default: return 8'($urandom);
        endcase
    endfunction

    t_row rows[$];
    t_request req;

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        mismatches = 0;
        stall_random = 1'b0;
        burst_left = 0;
        for (int i = 0; i < ENTRIES; i++) shadow_pal[i] = '0;
        shadow_enables = 5'd31;
        shadow_alpha = 1'b0;

        rows = '{
            '{REQ_READ,   8'd0,   8'd0,   32'hFFFF_FFFF, 1, 32'h0},
            '{REQ_READ,   8'd255, 8'd0,   32'h0,         1, 32'h0},
            '{REQ_WRITE,  8'd0,   8'd0,   32'h1020_3040, 1, 32'h0},
            '{REQ_WRITE,  8'd255, 8'd0,   32'hFFFF_FFFF, 1, 32'h0},
            '{REQ_READ,   8'd0,   8'd0,   32'h0,         1, 32'h1020_3040},
            '{REQ_READ,   8'd255, 8'd0,   32'h0,         1, 32'hFFFF_FFFF},
            '{REQ_WRITE,  8'd10,  8'd0,   32'hFF00_FF00, 0, 32'h0},
            '{REQ_WRITE,  8'd20,  8'd0,   32'h00FF_00FF, 0, 32'h0},
            '{REQ_GRAD,   8'd20,  8'd10,  32'h0,         1, 32'h0},
            '{REQ_READ,   8'd15,  8'd0,   32'h0,         0, 32'h0},
            '{REQ_GRAD,   8'd7,   8'd7,   32'h0,         1, 32'h0},
            '{REQ_GRAD,   8'd11,  8'd12,  32'h0,         1, 32'h0},
            '{REQ_INVERT, 8'd0,   8'd3,   32'h0,         1, 32'h0},
            '{REQ_READ,   8'd0,   8'd0,   32'h0,         1, 32'h10DF_CFBF},
            '{REQ_DEDUCT, 8'd255, 8'd250, 32'h0,         1, 32'h0},
            '{REQ_READ,   8'd255, 8'd0,   32'h0,         1, 32'hFFFF_FFFF},
            '{REQ_DEDUCT, 8'd0,   8'd0,   32'h0,         1, 32'h0},
            '{REQ_READ,   8'd0,   8'd0,   32'h0,         1, 32'hCFDF_CFBF},
            '{3'(REQ_BAD), 8'd1,  8'd2,   32'hFFFF_FFFF, 1, 32'h0},
            '{3'd7,       8'd255, 8'd255, 32'h0,         1, 32'h0},
            '{REQ_INVERT, 8'd255, 8'd0,   32'h0,         1, 32'h0},
            '{REQ_GRAD,   8'd0,   8'd255, 32'h0,         1, 32'h0},
            '{REQ_READ,   8'd128, 8'd0,   32'h0,         0, 32'h0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            req = '{rows[i].color, rows[i].idx_b, rows[i].idx_a, rows[i].kind};
            send_request(req, rows[i].has_fixed, rows[i].fixed_color);
        end
        drain_results();

        // Random phases under different register settings, extremes first.
        stall_random = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_register(CFG_ENABLES, 5'd0);  write_register(CFG_ALPHA, 1'b1); end
                1: begin write_register(CFG_ENABLES, 5'd31); write_register(CFG_ALPHA, 1'b1); end
                2: begin write_register(CFG_ENABLES, 5'd30); write_register(CFG_ALPHA, 1'b0); end
                default: begin
                    write_register(CFG_ENABLES, 5'($urandom));
                    write_register(CFG_ALPHA, 1'($urandom));
                end
            endcase
            if (phase == 5) stall_random = 1'b0;
            for (int n = 0; n < 75; n++) begin
                req.kind  = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4));
                req.idx_a = pick_index();
                req.idx_b = ($urandom_range(0, 3) == 0) ? pick_index()
                                                        : req.idx_a + 8'($urandom_range(0, 12));
                req.color = $urandom;
                send_request(req, 1'b0, '0);
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
